/* sv/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants for the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned PIX_W    = 8;   // one color channel
  localparam int unsigned HUE_W    = 16;  // hue result field
  localparam int unsigned SAT_W    = 16;  // saturation result field
  localparam int unsigned SAT_FRAC = 15;  // saturation is Q1.15
  localparam int unsigned NUM_W    = 11;  // holds 6 * 255

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [PIX_W-1:0] value;
  } hsv_t;

  // operands handed from the front end to the divider pipeline
  typedef struct packed {
    logic [NUM_W-1:0] hue_num;
    logic [NUM_W-1:0] hue_den;
    logic [PIX_W-1:0] sat_num;
    logic [PIX_W-1:0] sat_den;
    logic [PIX_W-1:0] value;
    logic             gray;
  } front_t;

endpackage

/* sv/rgbhsv_front.sv */
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two register stages: channel max/min and sector pick, then chroma and the
// hue numerator and divisor for the divider pipeline.
// ----------------------------------------------------------------------------
module rgbhsv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  rgbhsv_pkg::pix_t      pixel_i,
  output logic                  valid_o,
  output rgbhsv_pkg::front_t    front_o
);

  localparam int unsigned PW = rgbhsv_pkg::PIX_W;
  localparam int unsigned NW = rgbhsv_pkg::NUM_W;

  // stage a
  logic                    a_valid_q;
  rgbhsv_pkg::pix_t        a_pix_q;
  logic [PW-1:0]           a_hi_q, a_hi_d;
  logic [PW-1:0]           a_lo_q, a_lo_d;
  rgbhsv_pkg::chan_e       a_sel_q, a_sel_d;

  // stage b
  logic                    b_valid_q;
  rgbhsv_pkg::front_t      b_front_q, b_front_d;

  logic [PW-1:0]           r, g, b;
  logic [PW-1:0]           d;
  logic [NW-1:0]           d_ext, d6;

  assign r = pixel_i.red;
  assign g = pixel_i.green;
  assign b = pixel_i.blue;

  always_comb begin
    if ((r >= g) && (r >= b)) begin
      a_sel_d = rgbhsv_pkg::CH_RED;
    end else if (g >= b) begin
      a_sel_d = rgbhsv_pkg::CH_GREEN;
    end else begin
      a_sel_d = rgbhsv_pkg::CH_BLUE;
    end
    a_hi_d = (r > g) ? r : g;
    if (b > a_hi_d) begin
      a_hi_d = b;
    end
    a_lo_d = (r < g) ? r : g;
    if (b < a_lo_d) begin
      a_lo_d = b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pix_q <= pixel_i;
    a_hi_q  <= a_hi_d;
    a_lo_q  <= a_lo_d;
    a_sel_q <= a_sel_d;
  end

  assign d     = a_hi_q - a_lo_q;
  assign d_ext = NW'(d);
  assign d6    = (d_ext << 2) + (d_ext << 1);

  always_comb begin
    b_front_d.hue_den = d6;
    b_front_d.sat_num = d;
    b_front_d.sat_den = a_hi_q;
    b_front_d.value   = a_hi_q;
    b_front_d.gray    = (d == '0);
    unique case (a_sel_q)
      rgbhsv_pkg::CH_RED: begin
        // negative difference wraps by a full turn
        if (a_pix_q.green >= a_pix_q.blue) begin
          b_front_d.hue_num = NW'(a_pix_q.green) - NW'(a_pix_q.blue);
        end else begin
          b_front_d.hue_num = d6 - (NW'(a_pix_q.blue) - NW'(a_pix_q.green));
        end
      end
      rgbhsv_pkg::CH_GREEN: begin
        b_front_d.hue_num = (d_ext << 1) + NW'(a_pix_q.blue) - NW'(a_pix_q.red);
      end
      rgbhsv_pkg::CH_BLUE: begin
        b_front_d.hue_num = (d_ext << 2) + NW'(a_pix_q.red) - NW'(a_pix_q.green);
      end
      default: begin
        b_front_d.hue_num = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_front_q <= b_front_d;
  end

  assign valid_o = b_valid_q;
  assign front_o = b_front_q;

endmodule

/* sv/rgbhsv_div.sv */
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, one quotient bit per stage, running the hue
// and saturation divisions side by side. Each quotient is num * 2^QF / den
// with num <= den, so the first stage yields the integer bit.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int unsigned QF = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  rgbhsv_pkg::front_t         front_i,
  output logic                       valid_o,
  output logic [QF:0]                hue_quo_o,
  output logic [QF:0]                sat_quo_o,
  output logic [rgbhsv_pkg::PIX_W-1:0] value_o,
  output logic                       gray_o
);

  localparam int unsigned NSTG = QF + 1;
  localparam int unsigned QW   = QF + 1;
  localparam int unsigned HW   = rgbhsv_pkg::NUM_W;
  localparam int unsigned SW   = rgbhsv_pkg::PIX_W;

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] gray_q;
  logic [HW-1:0]   hrem_q [NSTG];
  logic [HW-1:0]   hden_q [NSTG];
  logic [SW-1:0]   srem_q [NSTG];
  logic [SW-1:0]   sden_q [NSTG];
  logic [SW-1:0]   val_q  [NSTG];
  logic [QW-1:0]   hquo_q [NSTG];
  logic [QW-1:0]   squo_q [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic          vld_s, gray_s;
    logic [HW-1:0] hden_s;
    logic [SW-1:0] sden_s, val_s;
    logic [QW-1:0] hquo_s, squo_s;
    logic [HW:0]   h_try, h_d;
    logic [SW:0]   s_try, s_d;
    logic          h_bit, s_bit;

    if (i == 0) begin : g_head
      assign vld_s  = valid_i;
      assign gray_s = front_i.gray;
      assign hden_s = front_i.hue_den;
      assign sden_s = front_i.sat_den;
      assign val_s  = front_i.value;
      assign hquo_s = '0;
      assign squo_s = '0;
      assign h_try  = {1'b0, front_i.hue_num};
      assign s_try  = {1'b0, front_i.sat_num};
    end else begin : g_body
      assign vld_s  = vld_q[i-1];
      assign gray_s = gray_q[i-1];
      assign hden_s = hden_q[i-1];
      assign sden_s = sden_q[i-1];
      assign val_s  = val_q[i-1];
      assign hquo_s = hquo_q[i-1];
      assign squo_s = squo_q[i-1];
      assign h_try  = {hrem_q[i-1], 1'b0};
      assign s_try  = {srem_q[i-1], 1'b0};
    end

    assign h_bit = (h_try >= {1'b0, hden_s});
    assign h_d   = h_bit ? (h_try - {1'b0, hden_s}) : h_try;
    assign s_bit = (s_try >= {1'b0, sden_s});
    assign s_d   = s_bit ? (s_try - {1'b0, sden_s}) : s_try;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_s;
      end
    end

    // remainder stays below the divisor, so the top bit drops
    always_ff @(posedge clk_i) begin
      gray_q[i] <= gray_s;
      hden_q[i] <= hden_s;
      sden_q[i] <= sden_s;
      val_q[i]  <= val_s;
      hrem_q[i] <= h_d[HW-1:0];
      srem_q[i] <= s_d[SW-1:0];
      hquo_q[i] <= {hquo_s[QW-2:0], h_bit};
      squo_q[i] <= {squo_s[QW-2:0], s_bit};
    end
  end

  assign valid_o   = vld_q[NSTG-1];
  assign hue_quo_o = hquo_q[NSTG-1];
  assign sat_quo_o = squo_q[NSTG-1];
  assign value_o   = val_q[NSTG-1];
  assign gray_o    = gray_q[NSTG-1];

endmodule

/* sv/rgb_to_hsv.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Converts one 8-bit RGB pixel to hue (Q0.16 of a turn), saturation (Q1.15)
// and value, one pixel per clock.
// ----------------------------------------------------------------------------
// The converter takes a pixel on every clock edge where start_i is high;
// busy_o is never raised, so one pixel per cycle is sustained without gaps.
// Each result appears on result_o for one cycle with valid_o high, in input
// order. It passes through two front-end stages, the divider pipeline,
// which resolves one quotient bit per stage, and the output register. The
// receiver must take every result as it comes.
// Gray pixels, black included, give hue 0 and saturation 0.
module rgb_to_hsv #(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rgbhsv_pkg::pix_t  pixel_i,
  output logic              valid_o,
  output rgbhsv_pkg::hsv_t  result_o
);

  localparam int unsigned QF  = (HUE_BITS > rgbhsv_pkg::SAT_FRAC) ?
                                HUE_BITS : rgbhsv_pkg::SAT_FRAC;
  localparam int unsigned QW  = QF + 1;
  localparam int unsigned HSH = QF - HUE_BITS;
  localparam int unsigned SSH = QF - rgbhsv_pkg::SAT_FRAC;
  localparam int unsigned LAT = QF + 4;

  logic                           accept;
  logic                           fr_valid;
  rgbhsv_pkg::front_t             fr_data;
  logic                           dv_valid;
  logic [QW-1:0]                  dv_hue, dv_sat;
  logic [rgbhsv_pkg::PIX_W-1:0]   dv_value;
  logic                           dv_gray;
  logic [QW-1:0]                  hue_sh, sat_sh;

  logic                           valid_q;
  rgbhsv_pkg::hsv_t               res_q, res_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .pixel_i (pixel_i),
    .valid_o (fr_valid),
    .front_o (fr_data)
  );

  rgbhsv_div #(
    .QF (QF)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (fr_valid),
    .front_i   (fr_data),
    .valid_o   (dv_valid),
    .hue_quo_o (dv_hue),
    .sat_quo_o (dv_sat),
    .value_o   (dv_value),
    .gray_o    (dv_gray)
  );

  // dropping extra fraction bits of an exact floor is still an exact floor
  assign hue_sh = dv_hue >> HSH;
  assign sat_sh = dv_sat >> SSH;

  always_comb begin
    res_d.value = dv_value;
    if (dv_gray) begin
      res_d.hue        = '0;
      res_d.saturation = '0;
    end else begin
      res_d.hue        = hue_sh[rgbhsv_pkg::HUE_W-1:0];
      res_d.saturation = sat_sh[rgbhsv_pkg::SAT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

  // saturation never exceeds one
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.saturation <= 16'd32768))
    else $error("saturation above 1.0");

  // a black pixel has no hue and no saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (result_o.value == '0)) |->
      ((result_o.hue == '0) && (result_o.saturation == '0)))
    else $error("black pixel with nonzero hue or saturation");

  // valid_o follows each accepted transaction through the whole pipeline, none lost or added
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, LAT) |-> (valid_o == $past(start_i && !busy_o, LAT)))
    else $error("result strobe does not match accepted transaction");

endmodule
